[rtl/lcsp_pkg.sv]
// Shared types and constants for the LED command stream parser.
package lcsp_pkg;

  localparam logic [7:0] MAX_LEDS = 8'd255;
  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  localparam logic [2:0] EV_PROTO     = 3'd0;
  localparam logic [2:0] EV_SERIAL    = 3'd1;
  localparam logic [2:0] EV_RESET     = 3'd2;
  localparam logic [2:0] EV_COUNT     = 3'd3;
  localparam logic [2:0] EV_UNLOCK    = 3'd4;
  localparam logic [2:0] EV_LED_WRITE = 3'd5;
  localparam logic [2:0] EV_FRAME_END = 3'd6;

  localparam logic [0:0] REG_LED_COUNT = 1'd0;
  localparam logic [0:0] REG_REVERSE   = 1'd1;

  localparam logic [39:0] NAME_PROTO = "proto";
  localparam logic [39:0] NAME_SNUMB = "snumb";
  localparam logic [39:0] NAME_RNUMB = "rnumb";
  localparam logic [39:0] NAME_LEDSC = "ledsc";
  localparam logic [39:0] NAME_UNLOC = "unloc";
  localparam logic [39:0] NAME_SLEDS = "sleds";

  // Token handed from the front (byte classifier) to the back (event builder).
  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] led_pos;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_valid;
  } tok_t;

  localparam int TOK_W = $bits(tok_t);
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

endpackage

[rtl/led_command_stream_parser.sv]
// Top level of the LED command stream parser.
// Usage:
//   Push one received byte per cycle on rx_byte with push; full stalls the
//   sender. Results come out as a queue: while empty is low the oldest
//   result sits on event_res, led_index, red, green, blue and frame_valid,
//   and pop takes it.
//   Each byte's result passes through the parser register, then the token
//   queue, before it reaches the outputs. One byte per cycle is sustained
//   while full stays low.
//   The parser issues at most one result per byte; a four-entry queue
//   absorbs a stalled reader, and full rises when one slot or none
//   remains free so a token already in the parser always finds room.
//   Configuration: led_count at 0x0, reverse_order at 0x4, written over
//   the APB port while the block is idle; pready is always high.
//   Reset (rst, synchronous) clears the parser to preamble hunting, empties
//   the queue and clears both registers.
module led_command_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  event_res,
  output logic [7:0]  led_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        frame_valid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]               led_count;
  logic                     reverse_order;
  logic                     tok_valid;
  lcsp_pkg::tok_t           tok;
  lcsp_pkg::tok_t           q_tok;
  logic [lcsp_pkg::QAW:0]   q_count;
  logic                     accept;
  logic                     take;

  assign pready = 1'b1;
  assign accept = push & ~full;
  assign take   = pop & ~empty;
  // one token may still be in the parser register
  assign full = q_count >= (lcsp_pkg::QAW+1)'(lcsp_pkg::QDEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count     <= 8'd0;
      reverse_order <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        lcsp_pkg::REG_LED_COUNT: led_count     <= pwdata[7:0];
        lcsp_pkg::REG_REVERSE:   reverse_order <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lcsp_pkg::REG_LED_COUNT: prdata = {24'd0, led_count};
      lcsp_pkg::REG_REVERSE:   prdata = {31'd0, reverse_order};
      default:                 prdata = 32'd0;
    endcase
  end

  lcsp_front u_front (
    .clk, .rst, .in_valid(accept), .rx_byte, .led_count, .tok_valid, .tok
  );

  lcsp_queue u_queue (
    .clk, .rst, .wr(tok_valid), .wdata(tok), .rd(take), .rdata(q_tok),
    .empty, .count(q_count)
  );

  lcsp_back u_back (
    .tok(q_tok), .led_count, .reverse_order, .event_res, .led_index,
    .red, .green, .blue, .frame_valid
  );

endmodule

[rtl/lcsp_front.sv]
// Front end: accepts bytes, runs the frame parser, issues tokens.
module lcsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          led_count,
  output logic                tok_valid,
  output lcsp_pkg::tok_t      tok
);

  typedef enum logic [1:0] {HUNT, CMD, LEDS, TERM} mode_t;

  mode_t       parse_mode;
  logic [1:0]  sync_count;
  logic [7:0]  command_chars [4];
  logic [2:0]  byte_position;
  logic [7:0]  led_position;
  logic [1:0]  color_phase;
  logic [7:0]  held_red;
  logic [7:0]  held_green;
  logic        terminator_ok;

  logic [7:0]  eff_count;
  logic [39:0] name;
  logic [7:0]  led_position_next;
  logic        term_bad;

  assign eff_count = (led_count > lcsp_pkg::MAX_LEDS) ? lcsp_pkg::MAX_LEDS : led_count;
  assign name = {command_chars[0], command_chars[1], command_chars[2],
                 command_chars[3], rx_byte};
  assign led_position_next = led_position + 8'd1;
  assign term_bad = rx_byte != (lcsp_pkg::SYNC_BYTE - {5'd0, byte_position});

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode    <= HUNT;
      sync_count    <= 2'd0;
      byte_position <= 3'd0;
      led_position  <= 8'd0;
      color_phase   <= 2'd0;
      held_red      <= 8'd0;
      held_green    <= 8'd0;
      terminator_ok <= 1'b1;
      tok_valid     <= 1'b0;
    end else begin
      tok_valid <= 1'b0;
      if (in_valid) begin
        unique case (parse_mode)
          HUNT: begin
            if (rx_byte == lcsp_pkg::SYNC_BYTE) begin
              if (sync_count != 2'd3) sync_count <= sync_count + 2'd1;
            end else if (sync_count == 2'd3) begin
              command_chars[0] <= rx_byte;
              byte_position    <= 3'd1;
              parse_mode       <= CMD;
            end else begin
              sync_count <= 2'd0;
            end
          end
          CMD: begin
            if (byte_position != 3'd4) begin
              command_chars[byte_position[1:0]] <= rx_byte;
              byte_position <= byte_position + 3'd1;
            end else if (name == lcsp_pkg::NAME_SLEDS) begin
              led_position <= 8'd0;
              color_phase  <= 2'd0;
              byte_position <= 3'd0;
              if (eff_count == 8'd0) begin
                parse_mode    <= TERM;
                terminator_ok <= 1'b1;
              end else begin
                parse_mode <= LEDS;
              end
            end else begin
              parse_mode    <= HUNT;
              sync_count    <= 2'd0;
              byte_position <= 3'd0;
              tok.led_pos <= 8'd0;
              tok.red <= 8'd0;
              tok.green <= 8'd0;
              tok.blue <= 8'd0;
              tok.frame_valid <= 1'b0;
              tok_valid <= 1'b1;
              case (name)
                lcsp_pkg::NAME_PROTO: tok.event_res <= lcsp_pkg::EV_PROTO;
                lcsp_pkg::NAME_SNUMB: tok.event_res <= lcsp_pkg::EV_SERIAL;
                lcsp_pkg::NAME_RNUMB: tok.event_res <= lcsp_pkg::EV_RESET;
                lcsp_pkg::NAME_LEDSC: tok.event_res <= lcsp_pkg::EV_COUNT;
                lcsp_pkg::NAME_UNLOC: tok.event_res <= lcsp_pkg::EV_UNLOCK;
                default: begin
                  tok.event_res <= lcsp_pkg::EV_PROTO;
                  tok_valid <= 1'b0;
                end
              endcase
            end
          end
          LEDS: begin
            if (color_phase == 2'd0) begin
              held_red    <= rx_byte;
              color_phase <= 2'd1;
            end else if (color_phase == 2'd1) begin
              held_green  <= rx_byte;
              color_phase <= 2'd2;
            end else begin
              tok_valid       <= 1'b1;
              tok.event_res   <= lcsp_pkg::EV_LED_WRITE;
              tok.led_pos     <= led_position;
              tok.red         <= held_red;
              tok.green       <= held_green;
              tok.blue        <= rx_byte;
              tok.frame_valid <= 1'b0;
              color_phase     <= 2'd0;
              led_position    <= led_position_next;
              if (led_position_next >= eff_count || led_position_next == 8'd0) begin
                parse_mode    <= TERM;
                byte_position <= 3'd0;
                terminator_ok <= 1'b1;
              end
            end
          end
          TERM: begin
            if (byte_position == 3'd2) begin
              tok_valid       <= 1'b1;
              tok.event_res   <= lcsp_pkg::EV_FRAME_END;
              tok.led_pos     <= 8'd0;
              tok.red         <= 8'd0;
              tok.green       <= 8'd0;
              tok.blue        <= 8'd0;
              tok.frame_valid <= terminator_ok & ~term_bad;
              terminator_ok   <= 1'b1;
              parse_mode      <= HUNT;
              sync_count      <= 2'd0;
              byte_position   <= 3'd0;
            end else begin
              if (term_bad) terminator_ok <= 1'b0;
              byte_position <= byte_position + 3'd1;
            end
          end
          default: parse_mode <= HUNT;
        endcase
      end
    end
  end

  a_term_pos: assert property (@(posedge clk) disable iff (rst)
    parse_mode == TERM |-> byte_position < 3'd3) else $error("terminator position overrun");
  a_color: assert property (@(posedge clk) disable iff (rst)
    color_phase != 2'd3) else $error("bad color phase");
  a_tok_after_in: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> $past(in_valid)) else $error("token without byte");

endmodule

[rtl/lcsp_queue.sv]
// Token queue between the front end and the back end.
module lcsp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  lcsp_pkg::tok_t       wdata,
  input  logic                 rd,
  output lcsp_pkg::tok_t       rdata,
  output logic                 empty,
  output logic [lcsp_pkg::QAW:0] count
);

  lcsp_pkg::tok_t              mem [lcsp_pkg::QDEPTH];
  logic [lcsp_pkg::QAW-1:0]    wptr;
  logic [lcsp_pkg::QAW-1:0]    rptr;

  assign empty = count == '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + {{lcsp_pkg::QAW{1'b0}}, wr} - {{lcsp_pkg::QAW{1'b0}}, rd};
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    wr && !rd |-> count < (lcsp_pkg::QAW+1)'(lcsp_pkg::QDEPTH)) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (rst)
    wr && !rd |=> count == $past(count) + 1'b1) else $error("count slip");

endmodule

[rtl/lcsp_back.sv]
// Back end: maps queued tokens to result fields, mirroring the LED index of LED writes when reverse_order is set.
module lcsp_back (
  input  lcsp_pkg::tok_t tok,
  input  logic [7:0]     led_count,
  input  logic           reverse_order,
  output logic [2:0]     event_res,
  output logic [7:0]     led_index,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue,
  output logic           frame_valid
);

  logic [7:0] eff_count;

  assign eff_count = (led_count > lcsp_pkg::MAX_LEDS) ? lcsp_pkg::MAX_LEDS : led_count;
  assign event_res = tok.event_res;
  // config must be held stable while the frame is in flight (not enforced here), so mirroring here is safe
  assign led_index = (reverse_order && tok.event_res == lcsp_pkg::EV_LED_WRITE)
                     ? (eff_count - 8'd1 - tok.led_pos) : tok.led_pos;
  assign red         = tok.red;
  assign green       = tok.green;
  assign blue        = tok.blue;
  assign frame_valid = tok.frame_valid;

endmodule

[test/led_command_stream_parser_checker.sv]
// Checker for the LED command stream parser: predicts events and compares them.
`timescale 1ns / 100ps
module led_command_stream_parser_checker
  import lcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  rx_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  event_res,
  input  logic [7:0]  led_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        frame_valid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [1:0] {HUNT, CMD, LEDS, TERM} mode_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [7:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       fv;
  } event_t;

  event_t     expected_events[$];
  logic [7:0] cfg_count;
  logic       cfg_reverse;
  mode_t      mode;
  logic [1:0] sync_cnt;
  logic [39:0] name_buf;
  logic [2:0] pos;
  logic [7:0] led_pos;
  logic [1:0] phase;
  logic [7:0] hold_r, hold_g;
  logic       term_ok;

  assign pending = expected_events.size();

  function automatic logic [7:0] led_limit();
    return (cfg_count > MAX_LEDS) ? MAX_LEDS : cfg_count;
  endfunction

  task automatic parse_byte(input logic [7:0] c);
    event_t e;
    logic [7:0] n;
    e = '0;
    case (mode)
      HUNT: begin
        if (c == SYNC_BYTE) begin
          if (sync_cnt < 3) sync_cnt++;
        end else if (sync_cnt == 3) begin
          name_buf = {c, 32'h0};
          pos = 1;
          mode = CMD;
        end else begin
          sync_cnt = 0;
        end
      end
      CMD: begin
        name_buf[39 - 8*pos -: 8] = c;
        pos++;
        if (pos == 5) begin
          if (name_buf == NAME_SLEDS) begin
            led_pos = 0;
            phase = 0;
            pos = 0;
            if (led_limit() == 0) begin
              mode = TERM;
              term_ok = 1;
            end else begin
              mode = LEDS;
            end
          end else begin
            mode = HUNT;
            sync_cnt = 0;
            pos = 0;
            e.ev = 3'h7;
            case (name_buf)
              NAME_PROTO: e.ev = EV_PROTO;
              NAME_SNUMB: e.ev = EV_SERIAL;
              NAME_RNUMB: e.ev = EV_RESET;
              NAME_LEDSC: e.ev = EV_COUNT;
              NAME_UNLOC: e.ev = EV_UNLOCK;
              default: ;
            endcase
            // drop unknown commands
            if (e.ev != 3'h7) expected_events.push_back(e);
          end
        end
      end
      LEDS: begin
        if (phase == 0) begin
          hold_r = c;
          phase = 1;
        end else if (phase == 1) begin
          hold_g = c;
          phase = 2;
        end else begin
          n = led_limit();
          e.ev = EV_LED_WRITE;
          e.idx = cfg_reverse ? 8'(n - 8'd1 - led_pos) : led_pos;
          e.r = hold_r;
          e.g = hold_g;
          e.b = c;
          expected_events.push_back(e);
          phase = 0;
          led_pos = led_pos + 8'd1;
          if (led_pos >= n || led_pos == 0) begin
            mode = TERM;
            pos = 0;
            term_ok = 1;
          end
        end
      end
      TERM: begin
        if (c != 8'(8'hFF - pos)) term_ok = 0;
        pos++;
        if (pos == 3) begin
          e.ev = EV_FRAME_END;
          e.fv = term_ok;
          expected_events.push_back(e);
          mode = HUNT;
          sync_cnt = 0;
          pos = 0;
          term_ok = 1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      cfg_count <= 0;
      cfg_reverse <= 0;
      mode = HUNT;
      sync_cnt = 0;
      pos = 0;
      led_pos = 0;
      phase = 0;
      hold_r = 0;
      hold_g = 0;
      term_ok = 1;
      name_buf = '0;
      fail_count <= 0;
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_REVERSE) cfg_reverse <= pwdata[0];
        else cfg_count <= pwdata[7:0];
      end
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event ev=%0d idx=%0d", $time, event_res, led_index);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_events.pop_front();
          if (want != {event_res, led_index, red, green, blue, frame_valid}) begin
            $display("%0t: mismatch expected ev=%0d idx=%0d rgb=%h%h%h fv=%0d",
                     $time, want.ev, want.idx, want.r, want.g, want.b, want.fv);
            $display("%0t:          actual ev=%0d idx=%0d rgb=%h%h%h fv=%0d",
                     $time, event_res, led_index, red, green, blue, frame_valid);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (push && !full) parse_byte(rx_byte);
    end
  end

endmodule

[test/led_command_stream_parser_tb.sv]
// Testbench top for the LED command stream parser: stimulus, config and verdict.
`timescale 1ns / 100ps
module led_command_stream_parser_tb;
  import lcsp_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        full;
  logic [7:0]  rx_byte = 0;
  logic        empty;
  logic        pop = 0;
  logic [2:0]  event_res;
  logic [7:0]  led_index, red, green, blue;
  logic        frame_valid;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          byte_total = 0;
  int          base_total = 0;
  int          pop_wait = 0;
  logic        feeding = 0;
  logic [7:0]  cur_count = 0;

  localparam int CYCLE_LIMIT = 400000;

  led_command_stream_parser dut (.*);
  led_command_stream_parser_checker chk (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // reader holds pop low for a random wait after each transaction, with calm stretches of back-to-back pops
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
      pop_wait = 0;
    end else if (pop && !empty) begin
      pop_wait = (cycles % 2000 < 300) ? 0 : $urandom_range(0, 3);
      pop <= (pop_wait == 0);
    end else if (pop_wait != 0) begin
      pop_wait--;
      pop <= (pop_wait == 0);
    end else begin
      pop <= 1;
    end
  end

  task automatic send(input logic [7:0] b);
    int gap;
    gap = (cycles % 1500 < 200) ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    byte_total++;
  endtask

  task automatic send_name(input logic [39:0] nm);
    for (int i = 4; i >= 0; i--) send(nm[8*i +: 8]);
  endtask

  task automatic preamble(input int n);
    repeat (n) send(8'hFF);
  endtask

  task automatic sleds_frame(input int n, input logic good);
    preamble(3);
    send_name(NAME_SLEDS);
    repeat (3 * n) send(8'($urandom_range(0, 255)));
    if (good) begin
      send(8'hFF); send(8'hFE); send(8'hFD);
    end else begin
      repeat (3) send(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] cnt, input logic rev);
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write({REG_LED_COUNT, 2'b00}, {24'h0, cnt});
    apb_write({REG_REVERSE, 2'b00}, {31'h0, rev});
    cur_count = cnt;
  endtask

  task automatic random_frame();
    int pick;
    logic [39:0] names [6];
    names = '{NAME_PROTO, NAME_SNUMB, NAME_RNUMB, NAME_LEDSC, NAME_UNLOC, NAME_SLEDS};
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      preamble($urandom_range(3, 5));
      send_name(names[$urandom_range(0, 4)]);
    end else if (pick < 8) begin
      sleds_frame(cur_count, $urandom_range(0, 3) != 0);
    end else if (pick == 8) begin
      preamble($urandom_range(0, 4));
      repeat ($urandom_range(1, 6)) send(8'($urandom_range(0, 255)));
    end else begin
      // near miss names, partial terminators
      preamble(3);
      send(names[$urandom_range(0, 5)][39:32]);
      repeat (4) send($urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every command, long and short preambles, zero LEDs
    preamble(2); send(8'h00);
    preamble(7); send_name(NAME_PROTO);
    preamble(3); send_name(NAME_SNUMB);
    preamble(3); send_name(NAME_RNUMB);
    preamble(3); send_name(NAME_LEDSC);
    preamble(3); send_name(NAME_UNLOC);
    preamble(3); send(8'hFF); send_name(40'h78FF00FF01);
    sleds_frame(0, 1);
    sleds_frame(0, 0);

    reconfigure(8'd2, 1'b1);
    sleds_frame(2, 1);
    reconfigure(8'd255, 1'b0);
    sleds_frame(255, 1);
    reconfigure(8'd255, 1'b1);
    sleds_frame(255, 0);

    base_total = byte_total;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: reconfigure(8'd1, 1'b0);
        1: reconfigure(8'd3, 1'b1);
        2: reconfigure(8'd0, 1'b0);
        3: reconfigure(8'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
        4: reconfigure(8'd5, 1'b1);
        default: reconfigure(8'($urandom_range(0, 12)), 1'b0);
      endcase
      while (byte_total < base_total + 35 * (ph + 1)) random_frame();
    end

    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
